// ===== hdl/irpd_pkg.sv =====
// Shared types and constants for the pulse-distance IR frame decoder.
package irpd_pkg;

  // Number of bits in one frame (8..32)
  localparam int unsigned FRAME_BITS = 32;
  localparam int unsigned BIT_W      = (FRAME_BITS > 1) ? $clog2(FRAME_BITS) : 1;

  // Interval width in microseconds and timer count width
  localparam int unsigned US_W    = 17;
  localparam int unsigned TICKS_W = 16;

  // ticks/92 = (ticks>>2)/23, done as a reciprocal multiply (exact for 14-bit operands)
  localparam int unsigned QUOT_IN_W  = TICKS_W - 2;
  localparam int unsigned DIV_SHIFT  = 19;
  localparam int unsigned RECIP_W    = 15;
  localparam logic [RECIP_W-1:0] DIV_RECIP = 15'd22796;
  localparam int unsigned PROD_W     = QUOT_IN_W + RECIP_W;
  localparam int unsigned QUOT_W     = PROD_W - DIV_SHIFT;

  // Input beat
  typedef struct packed {
    logic               kind;   // 0 edge event, 1 fetch key
    logic [TICKS_W-1:0] ticks;
  } in_t;

  // Result beat
  typedef struct packed {
    logic [7:0] key;
    logic       key_valid;
    logic       repeat_code;
    logic       frame_done;
  } out_t;

  // Timing windows, all bounds exclusive
  typedef struct packed {
    logic [US_W-1:0] lead_low;
    logic [US_W-1:0] lead_high;
    logic [US_W-1:0] repeat_low;
    logic [US_W-1:0] repeat_high;
    logic [US_W-1:0] zero_low;
    logic [US_W-1:0] zero_high;
    logic [US_W-1:0] one_low;
    logic [US_W-1:0] one_high;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    lead_low:    17'd13000,
    lead_high:   17'd14000,
    repeat_low:  17'd10750,
    repeat_high: 17'd11750,
    zero_low:    17'd620,
    zero_high:   17'd1520,
    one_low:     17'd1750,
    one_high:    17'd2650
  };

  localparam logic KIND_EDGE  = 1'b0;
  localparam logic KIND_FETCH = 1'b1;

endpackage

// ===== hdl/irpd_regs.sv =====
// APB-style register block holding the timing windows.
module irpd_regs (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [4:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready,
  output irpd_pkg::cfg_t cfg_o
);

  typedef enum logic [2:0] {
    REG_LEAD_LOW    = 3'd0,
    REG_LEAD_HIGH   = 3'd1,
    REG_REPEAT_LOW  = 3'd2,
    REG_REPEAT_HIGH = 3'd3,
    REG_ZERO_LOW    = 3'd4,
    REG_ZERO_HIGH   = 3'd5,
    REG_ONE_LOW     = 3'd6,
    REG_ONE_HIGH    = 3'd7
  } reg_idx_e;

  irpd_pkg::cfg_t cfg_q;
  reg_idx_e       idx;
  logic           wr_en;
  logic [irpd_pkg::US_W-1:0] wdata;
  logic [irpd_pkg::US_W-1:0] rdata;

  assign idx    = reg_idx_e'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign wdata  = pwdata[irpd_pkg::US_W-1:0];
  assign pready = 1'b1;

  // Register writes on the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= irpd_pkg::CFG_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_LEAD_LOW:    cfg_q.lead_low    <= wdata;
        REG_LEAD_HIGH:   cfg_q.lead_high   <= wdata;
        REG_REPEAT_LOW:  cfg_q.repeat_low  <= wdata;
        REG_REPEAT_HIGH: cfg_q.repeat_high <= wdata;
        REG_ZERO_LOW:    cfg_q.zero_low    <= wdata;
        REG_ZERO_HIGH:   cfg_q.zero_high   <= wdata;
        REG_ONE_LOW:     cfg_q.one_low     <= wdata;
        REG_ONE_HIGH:    cfg_q.one_high    <= wdata;
        default:         cfg_q             <= cfg_q;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (idx)
      REG_LEAD_LOW:    rdata = cfg_q.lead_low;
      REG_LEAD_HIGH:   rdata = cfg_q.lead_high;
      REG_REPEAT_LOW:  rdata = cfg_q.repeat_low;
      REG_REPEAT_HIGH: rdata = cfg_q.repeat_high;
      REG_ZERO_LOW:    rdata = cfg_q.zero_low;
      REG_ZERO_HIGH:   rdata = cfg_q.zero_high;
      REG_ONE_LOW:     rdata = cfg_q.one_low;
      REG_ONE_HIGH:    rdata = cfg_q.one_high;
      default:         rdata = '0;
    endcase
  end

  assign prdata = {{(32 - irpd_pkg::US_W){1'b0}}, rdata};
  assign cfg_o  = cfg_q;

endmodule

// ===== hdl/irpd_decode.sv =====
// Frame decoder state machine: scales the interval, classifies it, registers the result.
module irpd_decode (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  irpd_pkg::in_t  item_i,
  input  irpd_pkg::cfg_t cfg_i,
  output irpd_pkg::out_t res_o
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_WAIT = 2'd1,
    PH_RECV = 2'd2
  } phase_e;

  phase_e                      phase_q, phase_d;
  logic [irpd_pkg::BIT_W-1:0]  bit_count_q, bit_count_d;
  logic [31:0]                 frame_q, frame_d;
  logic                        ready_q, ready_d;
  irpd_pkg::out_t              res_q, res_d;

  logic [irpd_pkg::QUOT_IN_W-1:0] t4;
  logic [irpd_pkg::PROD_W-1:0]    prod;
  logic [irpd_pkg::QUOT_W-1:0]    quot;
  logic [irpd_pkg::US_W-1:0]      us;
  logic is_lead, is_rep, is_zero, is_one, check_ok;

  // us = (ticks / 92) * 100
  assign t4   = item_i.ticks[irpd_pkg::TICKS_W-1:2];
  assign prod = irpd_pkg::PROD_W'(t4) * irpd_pkg::PROD_W'(irpd_pkg::DIV_RECIP);
  assign quot = prod[irpd_pkg::PROD_W-1:irpd_pkg::DIV_SHIFT];
  assign us   = (irpd_pkg::US_W'(quot) << 6) + (irpd_pkg::US_W'(quot) << 5)
              + (irpd_pkg::US_W'(quot) << 2);

  // Window tests
  assign is_lead = (us > cfg_i.lead_low)   && (us < cfg_i.lead_high);
  assign is_rep  = (us > cfg_i.repeat_low) && (us < cfg_i.repeat_high);
  assign is_zero = (us > cfg_i.zero_low)   && (us < cfg_i.zero_high);
  assign is_one  = !is_zero && (us > cfg_i.one_low) && (us < cfg_i.one_high);

  // Address and command bytes against their complements
  assign check_ok = (frame_q[7:0] == ~frame_q[15:8]) && (frame_q[23:16] == ~frame_q[31:24]);

  // Next state and result
  always_comb begin
    phase_d     = phase_q;
    bit_count_d = bit_count_q;
    frame_d     = frame_q;
    ready_d     = ready_q;
    res_d       = '0;
    if (item_i.kind == irpd_pkg::KIND_FETCH) begin
      if (ready_q && check_ok) begin
        res_d.key       = frame_q[23:16];
        res_d.key_valid = 1'b1;
        ready_d         = 1'b0;
      end
    end else begin
      case (phase_q)
        PH_WAIT: begin
          if (is_lead) begin
            phase_d     = PH_RECV;
            bit_count_d = '0;
          end else if (is_rep) begin
            res_d.repeat_code = 1'b1;
          end
        end
        PH_RECV: begin
          if (is_zero || is_one) begin
            frame_d[bit_count_q] = is_one;
            if (bit_count_q == irpd_pkg::BIT_W'(irpd_pkg::FRAME_BITS - 1)) begin
              bit_count_d      = '0;
              phase_d          = PH_IDLE;
              ready_d          = 1'b1;
              res_d.frame_done = 1'b1;
            end else begin
              bit_count_d = bit_count_q + 1'b1;
            end
          end else begin
            phase_d     = PH_WAIT;
            bit_count_d = '0;
          end
        end
        default: phase_d = PH_WAIT;
      endcase
    end
  end

  // State and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      bit_count_q <= '0;
      frame_q     <= '0;
      ready_q     <= 1'b0;
      res_q       <= '0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      bit_count_q <= bit_count_d;
      frame_q     <= frame_d;
      ready_q     <= ready_d;
      res_q       <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// ===== hdl/ir_pulse_distance_frame_decoder_top.sv =====
// Top level of the pulse-distance IR frame decoder.
//
// Input channel (in_valid_i / in_stall_o / in_item_i): one beat per falling
// edge (kind = 0, ticks = timer count since the previous edge) or per key
// fetch (kind = 1). Every input beat yields exactly one result beat on the
// output channel (out_valid_o / out_stall_i / out_item_o), in order.
// Each accepted beat waits in the input register until the result register
// is free, then passes through the scale/classify/shift logic into the
// result register, which drives out_valid_o. The two stages are the input
// register and the scale/classify/shift logic into the result register.
// Throughput is one beat per cycle while out_stall_i is low, set by the single
// decode pass that updates the frame state at the result register.
// When the receiver stalls, the result register holds and the input register
// keeps its beat or takes one more if it was empty; then in_stall_o rises
// until the stalled result is taken.
// Timing windows are set over the APB-style port (register i at 4*i) and
// should only be written while no beats are in flight.
// Reset clears the pipeline, the frame state and loads default windows.
module ir_pulse_distance_frame_decoder_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  irpd_pkg::in_t  in_item_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output irpd_pkg::out_t out_item_o,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [4:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  irpd_pkg::cfg_t cfg;
  irpd_pkg::in_t  item_q;
  logic           item_vld_q;
  logic           out_vld_q;
  logic           step;
  logic           res_free;

  irpd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Result register can take a beat when empty or being drained
  assign res_free   = !out_vld_q || !out_stall_i;
  assign step       = item_vld_q && res_free;
  assign in_stall_o = item_vld_q && !res_free;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      item_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  // Output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_free) begin
      out_vld_q <= step;
    end
  end

  irpd_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (out_item_o)
  );

  assign out_valid_o = out_vld_q;

endmodule

// ===== hdl/irpd_checker.sv =====
// Port-level checks for the IR frame decoder, bound to the top level.
module irpd_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input irpd_pkg::out_t out_item_o
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result beat changed");

  // A returned key never comes with edge flags
  a_key_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.key_valid |-> !out_item_o.repeat_code && !out_item_o.frame_done)
    else $error("key beat carries edge flags");

  // No key byte without a checked frame
  a_key_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.key_valid |-> out_item_o.key == 8'd0)
    else $error("key byte without key_valid");

  // One edge cannot be both a repeat code and the last frame bit
  a_edge_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_item_o.repeat_code && out_item_o.frame_done))
    else $error("repeat code and frame done together");

endmodule

bind ir_pulse_distance_frame_decoder_top irpd_checker u_irpd_checker (.*);
